// ===== design/rsf_pkg.sv =====
`default_nettype none

package rsf_pkg;

    // one rgb pixel as stored in the line stores and the window
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    // line store control from the top level
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_lb_ctrl;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 12;
    localparam int COL_POS_W      = 10;
    localparam int ROW_POS_W      = 12;
    localparam int CFG_DATA_W     = 12;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // smallest frame side the window needs
    localparam int MIN_SIDE = 3;

    // 5*centre - up - down - left - right, clamped to 0..255
    function automatic logic [7:0] sharpen_chan(
        input logic [7:0] cen,
        input logic [7:0] up,
        input logic [7:0] down,
        input logic [7:0] left,
        input logic [7:0] right
    );
        logic [10:0] pos;
        logic [10:0] neg;
        logic [10:0] diff;
        logic [7:0]  res;
        pos  = {1'b0, cen, 2'b00} + {3'b000, cen};
        neg  = {3'b000, up} + {3'b000, down} + {3'b000, left} + {3'b000, right};
        diff = pos - neg;
        if (neg > pos) begin
            res = 8'd0;
        end else if (diff > 11'd255) begin
            res = 8'd255;
        end else begin
            res = diff[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/rsf_linebuf.sv =====
`default_nettype none

// two line stores, one read and one write per cycle each
// entries past the fill mark were never written and read as zero
module rsf_linebuf import rsf_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int AW = $clog2(MAX_WIDTH),
    localparam int FW = $clog2(MAX_WIDTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_lb_ctrl      i_ctrl,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_pixel        i_wr_px,
    output t_pixel             o_top,
    output t_pixel             o_mid
);

    t_pixel r_mem_upper  [MAX_WIDTH];
    t_pixel r_mem_middle [MAX_WIDTH];
    t_pixel r_rd_upper;
    t_pixel r_rd_middle;
    logic   r_rd_ok;
    logic [FW-1:0] r_fill;
    logic [FW-1:0] rd_addr_ext;

    assign rd_addr_ext = FW'(i_rd_addr);

    // columns are visited in order from zero, so the written part is a prefix
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_rd_ok <= 1'b0;
        end else if (i_ctrl.rd_en) begin
            r_rd_ok <= rd_addr_ext < r_fill;
            if (rd_addr_ext == r_fill) begin
                r_fill <= r_fill + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.wr_en) begin
            r_mem_upper[i_wr_addr]  <= o_mid;
            r_mem_middle[i_wr_addr] <= i_wr_px;
        end
        if (i_ctrl.rd_en) begin
            r_rd_upper  <= r_mem_upper[i_rd_addr];
            r_rd_middle <= r_mem_middle[i_rd_addr];
        end
    end

    assign o_top = r_rd_ok ? r_rd_upper : '0;
    assign o_mid = r_rd_ok ? r_rd_middle : '0;

endmodule

`default_nettype wire

// ===== design/rsf_sharpen.sv =====
`default_nettype none

// laplacian sharpen of one window, all three channels
module rsf_sharpen import rsf_pkg::*; (
    input  wire t_pixel i_cen,
    input  wire t_pixel i_up,
    input  wire t_pixel i_down,
    input  wire t_pixel i_left,
    input  wire t_pixel i_right,
    output t_pixel      o_px
);

    assign o_px.red   = sharpen_chan(i_cen.red, i_up.red, i_down.red,
                                     i_left.red, i_right.red);
    assign o_px.green = sharpen_chan(i_cen.green, i_up.green, i_down.green,
                                     i_left.green, i_right.green);
    assign o_px.blue  = sharpen_chan(i_cen.blue, i_up.blue, i_down.blue,
                                     i_left.blue, i_right.blue);

endmodule

`default_nettype wire

// ===== design/rgb_sharpen_3x3_filter.sv =====
// path: a result word passes the middle stage, then the output register, after the pixel
//   that completes its window (the pixel below and right of the centre) is taken
// throughput: one pixel per cycle unless stalled, set by one read and write port per store
// reset: position counters, valid flags and fill mark clear, frame size goes to 640 x 480;
//   the line stores are not swept, unwritten columns read as zero through the fill mark
`default_nettype none

module rgb_sharpen_3x3_filter import rsf_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // pixel input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [7:0]            i_red,
    input  wire logic [7:0]            i_green,
    input  wire logic [7:0]            i_blue,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [7:0]                 o_sharp_red,
    output logic [7:0]                 o_sharp_green,
    output logic [7:0]                 o_sharp_blue,
    output logic [COL_POS_W-1:0]       o_col_pos,
    output logic [ROW_POS_W-1:0]       o_row_pos,
    output logic                       o_frame_last,
    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic                  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [12:0] MAX_W = 13'(MAX_WIDTH);
    localparam logic [12:0] MIN_S = 13'(MIN_SIDE);

    // configuration registers
    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;

    // position of the next incoming pixel
    logic [CW-1:0]        r_col;
    logic [ROW_POS_W-1:0] r_row;
    logic [CW-1:0]        n_col;
    logic [ROW_POS_W-1:0] n_row;

    // stage between the input and the output register
    logic                 r_b_vld;
    logic                 r_b_emit;
    t_pixel               r_b_px;
    logic [CW-1:0]        r_b_col;
    logic [COL_POS_W-1:0] r_b_col_pos;
    logic [ROW_POS_W-1:0] r_b_row_pos;
    logic                 r_b_last;

    // window: one column back for up, centre and down, two back for left
    t_pixel r_win_up;
    t_pixel r_win_cen;
    t_pixel r_win_left;
    t_pixel r_win_down;

    // output register
    logic   r_out_valid;
    t_pixel r_out_px;
    logic [COL_POS_W-1:0] r_out_col_pos;
    logic [ROW_POS_W-1:0] r_out_row_pos;
    logic   r_out_last;

    logic        advance;
    logic        accept;
    logic [12:0] eff_w;
    logic [12:0] eff_h;
    logic        col_wrap;
    logic        row_wrap;
    logic        emit;
    logic [CW-1:0]        col_m1;
    logic [ROW_POS_W-1:0] row_m1;
    t_pixel   in_px;
    t_pixel   lb_top;
    t_pixel   lb_mid;
    t_pixel   sharp_px;
    t_lb_ctrl lb_ctrl;

    // whole pipe moves unless a finished word is held by the consumer
    assign advance    = !(r_out_valid && i_out_stall);
    assign o_in_stall = !advance;
    assign accept     = i_in_valid && advance;
    assign o_cfg_ready = 1'b1;

    assign in_px.red   = i_red;
    assign in_px.green = i_green;
    assign in_px.blue  = i_blue;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective frame size: width held to 3..MAX_WIDTH, height to at least 3
    always_comb begin
        eff_w = 13'(r_frame_width);
        if (eff_w < MIN_S) begin
            eff_w = MIN_S;
        end
        if (eff_w > MAX_W) begin
            eff_w = MAX_W;
        end
        eff_h = 13'(r_frame_height);
        if (eff_h < MIN_S) begin
            eff_h = MIN_S;
        end
    end

    assign col_wrap = (13'(r_col) + 13'd1) >= eff_w;
    assign row_wrap = (13'(r_row) + 13'd1) >= eff_h;
    // interior centre is one row up and one column left of the incoming pixel
    assign emit     = (r_row >= ROW_POS_W'(2)) && (r_col >= CW'(2));
    assign col_m1   = r_col - CW'(1);
    assign row_m1   = r_row - ROW_POS_W'(1);

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (col_wrap) begin
            n_col = '0;
            n_row = row_wrap ? '0 : r_row + ROW_POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_b_vld <= 1'b0;
        end else if (advance) begin
            r_b_vld <= i_in_valid;
            if (i_in_valid) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_emit    <= emit;
            r_b_px      <= in_px;
            r_b_col     <= r_col;
            r_b_col_pos <= COL_POS_W'(col_m1);
            r_b_row_pos <= row_m1;
            r_b_last    <= row_wrap && col_wrap;
        end
    end

    // line stores: read at accept, written back when the word leaves this stage
    assign lb_ctrl.rd_en = accept;
    assign lb_ctrl.wr_en = advance && r_b_vld;

    rsf_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (lb_ctrl),
        .i_rd_addr (r_col),
        .i_wr_addr (r_b_col),
        .i_wr_px   (r_b_px),
        .o_top     (lb_top),
        .o_mid     (lb_mid)
    );

    // right neighbor is the middle-row pixel just read
    rsf_sharpen u_sharpen (
        .i_cen   (r_win_cen),
        .i_up    (r_win_up),
        .i_down  (r_win_down),
        .i_left  (r_win_left),
        .i_right (lb_mid),
        .o_px    (sharp_px)
    );

    // window shift, one column per pixel
    always_ff @(posedge i_clk) begin
        if (advance && r_b_vld) begin
            r_win_up   <= lb_top;
            r_win_left <= r_win_cen;
            r_win_cen  <= lb_mid;
            r_win_down <= r_b_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_b_vld && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_b_vld && r_b_emit) begin
            r_out_px      <= sharp_px;
            r_out_col_pos <= r_b_col_pos;
            r_out_row_pos <= r_b_row_pos;
            r_out_last    <= r_b_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sharp_red   = r_out_px.red;
    assign o_sharp_green = r_out_px.green;
    assign o_sharp_blue  = r_out_px.blue;
    assign o_col_pos     = r_out_col_pos;
    assign o_row_pos     = r_out_row_pos;
    assign o_frame_last  = r_out_last;

endmodule

`default_nettype wire

// ===== design/rsf_checker.sv =====
`default_nettype none

module rsf_props import rsf_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_in_valid,
    input wire logic                 o_in_stall,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_stall,
    input wire logic [7:0]           o_sharp_red,
    input wire logic [7:0]           o_sharp_green,
    input wire logic [7:0]           o_sharp_blue,
    input wire logic [COL_POS_W-1:0] o_col_pos,
    input wire logic [ROW_POS_W-1:0] o_row_pos,
    input wire logic                 o_frame_last
);

    // held word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sharp_red)
            && $stable(o_sharp_green) && $stable(o_sharp_blue)
            && $stable(o_col_pos) && $stable(o_row_pos) && $stable(o_frame_last))
        else $error("result word changed while stalled");

    // input is only held back by a stalled result
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // centre row is never the top border
    a_row_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_row_pos != '0)
        else $error("result on top border row");

    // a new result only appears after the pipe was moving
    a_rise_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_stall))
        else $error("result appeared while pipe was frozen");

endmodule

bind rgb_sharpen_3x3_filter rsf_props u_rsf_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sharp_red   (o_sharp_red),
    .o_sharp_green (o_sharp_green),
    .o_sharp_blue  (o_sharp_blue),
    .o_col_pos     (o_col_pos),
    .o_row_pos     (o_row_pos),
    .o_frame_last  (o_frame_last)
);

`default_nettype wire
